// ===== rtl/pgpc_pkg.sv =====
// shared types and constants for the polar go-to-pose controller
`timescale 1ns / 1ps
package pgpc_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [47:0] HALF_PI_Q24 = 48'sd26353589;
    localparam logic signed [17:0] INV_K_Q16 = 18'sd39797;
    localparam logic signed [17:0] PI13 = 18'sd25736;
    localparam logic signed [22:0] V_SCALE_Q8 = 23'sd1969231;
    localparam logic signed [17:0] HALF_W_SCALE_Q8 = 18'sd54325;
    localparam logic [15:0] RHO_NEAR = 16'd9;

    localparam logic [2:0] REG_GOAL_X = 3'd0;
    localparam logic [2:0] REG_GOAL_Y = 3'd1;
    localparam logic [2:0] REG_DEADBAND = 3'd2;
    localparam logic [2:0] REG_GAIN_RHO = 3'd3;
    localparam logic [2:0] REG_GAIN_ALPHA = 3'd4;
    localparam logic [2:0] REG_GAIN_BETA = 3'd5;

    typedef struct packed {
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic signed [15:0] pose_heading;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic               at_goal;
    } wheel_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } cfg_t;

    function automatic logic signed [47:0] atan_q24(input logic [4:0] i);
        logic signed [47:0] r;
        begin
            case (i)
                5'd0: r = 48'sd13176795;
                5'd1: r = 48'sd7778716;
                5'd2: r = 48'sd4110060;
                5'd3: r = 48'sd2086331;
                5'd4: r = 48'sd1047214;
                5'd5: r = 48'sd524117;
                5'd6: r = 48'sd262123;
                5'd7: r = 48'sd131069;
                5'd8: r = 48'sd65536;
                5'd9: r = 48'sd32768;
                5'd10: r = 48'sd16384;
                5'd11: r = 48'sd8192;
                5'd12: r = 48'sd4096;
                5'd13: r = 48'sd2048;
                5'd14: r = 48'sd1024;
                5'd15: r = 48'sd512;
                5'd16: r = 48'sd256;
                5'd17: r = 48'sd128;
                5'd18: r = 48'sd64;
                5'd19: r = 48'sd32;
                5'd20: r = 48'sd16;
                5'd21: r = 48'sd8;
                5'd22: r = 48'sd4;
                5'd23: r = 48'sd2;
                default: r = 48'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/pgpc_if.sv =====
// valid/ready channel interfaces
`timescale 1ns / 1ps
interface pgpc_pose_if;
    import pgpc_pkg::*;
    logic  valid;
    logic  ready;
    pose_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pgpc_wheel_if;
    import pgpc_pkg::*;
    logic   valid;
    logic   ready;
    wheel_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pgpc_cfg_if;
    import pgpc_pkg::*;
    logic valid;
    logic ready;
    cfg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/pgpc_cordic_cell.sv =====
// one cordic micro-rotation cell, registered, with fixed shift and angle
`timescale 1ns / 1ps
module pgpc_cordic_cell #(
    parameter int STAGE = 0,
    parameter int XW = 26
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [XW-1:0]  in_x,
    input  logic signed [XW-1:0]  in_y,
    input  logic signed [47:0]    in_z,
    output logic                  out_valid,
    output logic signed [XW-1:0]  out_x,
    output logic signed [XW-1:0]  out_y,
    output logic signed [47:0]    out_z
);
    import pgpc_pkg::*;

    logic valid_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [47:0] z_reg, z_next;
    logic signed [47:0] ang;

    assign ang = atan_q24(5'(STAGE));

    always_comb
    begin
        if (in_y >= 0)
        begin
            x_next = in_x + (in_y >>> STAGE);
            y_next = in_y - (in_x >>> STAGE);
            z_next = in_z + ang;
        end
        else
        begin
            x_next = in_x - (in_y >>> STAGE);
            y_next = in_y + (in_x >>> STAGE);
            z_next = in_z - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign out_valid = valid_reg;
    assign out_x = x_reg;
    assign out_y = y_reg;
    assign out_z = z_reg;
endmodule

// ===== rtl/pgpc_law.sv =====
// polar control law, wheel mixing, saturation and deadband over a short pipeline
`timescale 1ns / 1ps
module pgpc_law #(
    parameter int XW = 26
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic signed [XW-1:0]  in_x,
    input  logic signed [47:0]    in_z,
    input  logic                  in_zero,
    input  logic signed [15:0]    heading,
    input  logic signed [15:0]    gain_rho,
    input  logic signed [15:0]    gain_alpha,
    input  logic signed [15:0]    gain_beta,
    input  logic [9:0]            deadband,
    output logic                  out_valid,
    output logic signed [15:0]    left_speed,
    output logic signed [15:0]    right_speed,
    output logic                  rho_near
);
    import pgpc_pkg::*;

    // stage 1: rho product and rounded angle
    logic [4:0] v_reg;
    logic signed [XW+18:0] rp_reg;
    logic signed [17:0] ang_reg, hd1_reg;
    logic signed [XW:0] xc;
    logic signed [47:0] zr;
    // stage 2: rho, alpha, beta
    logic signed [XW+18:0] rsum;
    logic signed [17:0] rho2_reg, al2_reg, be2_reg;
    logic signed [17:0] a0, a1, b0, b1;
    // stage 3: gain products
    logic signed [35:0] vv_reg, wa_reg, wb_reg;
    logic signed [17:0] rho3_reg;
    // stage 4: scaled parts
    logic signed [63:0] vp_reg, wp_reg;
    logic signed [36:0] w4;
    logic signed [17:0] rho4_reg;
    // stage 5
    logic signed [15:0] l_next, r_next;

    function automatic logic signed [17:0] wrap13(input logic signed [17:0] a);
        logic signed [17:0] r;
        begin
            r = a;
            if (r > PI13)
                r = r - 18'(2 * PI13);
            else if (r < -PI13)
                r = r + 18'(2 * PI13);
            return r;
        end
    endfunction

    function automatic logic signed [15:0] wheel(input logic signed [64:0] n,
                                                 input logic [9:0] mn);
        logic signed [64:0] s, mag;
        begin
            s = n < 0 ? -((-n) >>> 33) : (n >>> 33);
            if (s > 65'sd32767)
                s = 65'sd32767;
            if (s < -65'sd32768)
                s = -65'sd32768;
            mag = s < 0 ? -s : s;
            if (mag < $signed({55'd0, mn}))
                s = '0;
            return s[15:0];
        end
    endfunction

    assign xc = in_x < 0 ? '0 : {in_x[XW-1], in_x};
    assign zr = in_zero ? 48'sd1024 : in_z + 48'sd1024;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[3:0], in_valid};
    end

    assign rsum = rp_reg + (XW+19)'(64'sd1 << 23);
    assign a0 = ang_reg - hd1_reg;
    assign a1 = wrap13(a0);
    assign b0 = -hd1_reg - a1;
    assign b1 = wrap13(b0);
    assign w4 = (37)'(wa_reg) + (37)'(wb_reg);

    always_ff @(posedge clk)
    begin
        rp_reg <= (XW+19)'(xc) * (XW+19)'(INV_K_Q16);
        ang_reg <= 18'(zr >>> 11);
        hd1_reg <= 18'(heading);
        rho2_reg <= 18'(rsum >>> 24);
        al2_reg <= a1;
        be2_reg <= b1;
        vv_reg <= 36'(gain_rho) * 36'(rho2_reg);
        wa_reg <= 36'(gain_alpha) * 36'(al2_reg);
        wb_reg <= 36'(gain_beta) * 36'(be2_reg);
        rho3_reg <= rho2_reg;
        vp_reg <= 64'(vv_reg) * 64'(V_SCALE_Q8) * 64'sd2;
        wp_reg <= 64'(w4) * 64'(HALF_W_SCALE_Q8);
        rho4_reg <= rho3_reg;
        left_speed <= l_next;
        right_speed <= r_next;
        rho_near <= rho4_reg < $signed({2'b0, RHO_NEAR});
    end

    assign l_next = wheel(65'(vp_reg) - 65'(wp_reg), deadband);
    assign r_next = wheel(65'(vp_reg) + 65'(wp_reg), deadband);
    assign out_valid = v_reg[4];
endmodule

// ===== rtl/polar_goto_pose_controller_top.sv =====
// Polar go-to-pose controller for a differential-drive robot.
// Channels: pose (sink) takes pose_x, pose_y, pose_heading; wheel (source)
// gives left_speed, right_speed, at_goal; cfg writes registers by index:
// 0 goal_x, 1 goal_y, 2 min_wheel_speed, 3 gain_rho, 4 gain_alpha, 5 gain_beta.
// A pose is taken only when the block is empty; it passes a pre-rotation
// stage, a chain of CORDIC_ITERATIONS rotation cells and a five-stage
// control-law pipeline before the result is loaded into the output register.
// One pose is in flight at a time and the next is taken the cycle after the
// result is read. The result sits in an output register until taken; while
// the receiver stalls no new pose is taken.
// Reset restores the register defaults and sets at_goal; writing a goal
// register clears at_goal; a result with both speeds zero or rho below
// 0.002 m sets it again. Iterations above 24 are clamped to 24.
`timescale 1ns / 1ps
module polar_goto_pose_controller_top #(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int COORD_WIDTH = 16
) (
    input logic clk,
    input logic rst_n,
    pgpc_pose_if.sink    pose,
    pgpc_wheel_if.source wheel,
    pgpc_cfg_if.sink     cfg
);
    import pgpc_pkg::*;

    localparam int N = CORDIC_ITERATIONS > ATAN_ENTRIES ? ATAN_ENTRIES : CORDIC_ITERATIONS;
    // difference, guard bits, cordic gain on a diagonal vector
    localparam int XW = COORD_WIDTH + 11;

    logic signed [15:0] goal_x_reg, goal_y_reg, g_rho_reg, g_al_reg, g_be_reg;
    logic [9:0] min_reg;
    logic reached_reg, busy_reg, out_valid_reg;
    wheel_t out_reg;

    logic signed [15:0] hd_reg;
    logic zero_reg;
    logic accept;
    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] x0_reg, y0_reg;
    logic signed [47:0] z0_reg;
    logic v0_reg;

    logic               cv [0:N];
    logic signed [XW-1:0] cx [0:N];
    logic signed [XW-1:0] cy [0:N];
    logic signed [47:0]   cz [0:N];

    logic lv;
    logic signed [15:0] ls, rs;
    logic near;

    assign accept = pose.valid && pose.ready;
    assign pose.ready = !busy_reg;
    assign cfg.ready = 1'b1;

    assign dx = XW'($signed(goal_x_reg[COORD_WIDTH > 16 ? 15 : COORD_WIDTH-1:0]))
              - XW'($signed(pose.data.pose_x[COORD_WIDTH > 16 ? 15 : COORD_WIDTH-1:0]));
    assign dy = XW'($signed(goal_y_reg[COORD_WIDTH > 16 ? 15 : COORD_WIDTH-1:0]))
              - XW'($signed(pose.data.pose_y[COORD_WIDTH > 16 ? 15 : COORD_WIDTH-1:0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            min_reg <= 10'd1;
            g_rho_reg <= 16'sd4915;
            g_al_reg <= 16'sd6144;
            g_be_reg <= -16'sd1434;
            reached_reg <= 1'b1;
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
            if (accept)
                busy_reg <= 1'b1;
            if (lv)
            begin
                out_valid_reg <= 1'b1;
                if ((ls == 0 && rs == 0) || near)
                    reached_reg <= 1'b1;
            end
            else if (wheel.ready && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
                busy_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                unique case (cfg.data.index)
                    REG_GOAL_X:
                    begin
                        goal_x_reg <= cfg.data.data;
                        reached_reg <= 1'b0;
                    end
                    REG_GOAL_Y:
                    begin
                        goal_y_reg <= cfg.data.data;
                        reached_reg <= 1'b0;
                    end
                    REG_DEADBAND: min_reg <= cfg.data.data[9:0];
                    REG_GAIN_RHO: g_rho_reg <= cfg.data.data;
                    REG_GAIN_ALPHA: g_al_reg <= cfg.data.data;
                    REG_GAIN_BETA: g_be_reg <= cfg.data.data;
                    default: ;
                endcase
            end
        end
    end

    // pre-rotate into the right half plane
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hd_reg <= pose.data.pose_heading;
            zero_reg <= (dx == 0) && (dy == 0);
            if (dx < 0)
            begin
                if (dy >= 0)
                begin
                    x0_reg <= dy <<< 8;
                    y0_reg <= -(dx <<< 8);
                    z0_reg <= HALF_PI_Q24;
                end
                else
                begin
                    x0_reg <= -(dy <<< 8);
                    y0_reg <= dx <<< 8;
                    z0_reg <= -HALF_PI_Q24;
                end
            end
            else
            begin
                x0_reg <= dx <<< 8;
                y0_reg <= dy <<< 8;
                z0_reg <= '0;
            end
        end
        if (lv)
            out_reg <= '{left_speed: ls, right_speed: rs,
                         at_goal: ((ls == 0 && rs == 0) || near) ? 1'b1 : reached_reg};
    end

    assign cv[0] = v0_reg;
    assign cx[0] = x0_reg;
    assign cy[0] = y0_reg;
    assign cz[0] = z0_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        pgpc_cordic_cell #(.STAGE(g), .XW(XW)) u_cell (
            .clk(clk), .rst_n(rst_n),
            .in_valid(cv[g]), .in_x(cx[g]), .in_y(cy[g]), .in_z(cz[g]),
            .out_valid(cv[g+1]), .out_x(cx[g+1]), .out_y(cy[g+1]), .out_z(cz[g+1])
        );
    end

    pgpc_law #(.XW(XW)) u_law (
        .clk(clk), .rst_n(rst_n),
        .in_valid(cv[N]), .in_x(cx[N]), .in_z(cz[N]), .in_zero(zero_reg),
        .heading(hd_reg), .gain_rho(g_rho_reg), .gain_alpha(g_al_reg),
        .gain_beta(g_be_reg), .deadband(min_reg),
        .out_valid(lv), .left_speed(ls), .right_speed(rs), .rho_near(near)
    );

    assign wheel.valid = out_valid_reg;
    assign wheel.data = out_reg;
endmodule
